>>> design/bpoe_pkg.sv
// Package for the binary pair orbit elements block: types, constants and
// fixed-point helper functions shared by the sequencer and its units.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bpoe_pkg;

    localparam int MAX_BODIES = 16384;
    localparam logic [14:0] MAX_BODIES_LIM = 15'(MAX_BODIES);
    localparam logic [18:0] TWO_PI_Q = 19'd411775;
    localparam logic [16:0] ONE_Q = 17'd65536;
    localparam logic signed [31:0] Q_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh80000000;
    localparam logic [6:0] IUS_DIV_STEPS = 7'd64;
    localparam logic [6:0] IUS_SQRT_STEPS = 7'd32;

    localparam logic CFG_ONLY_BOUND = 1'b0;
    localparam logic CFG_BODY_COUNT = 1'b1;

    typedef enum logic {
        IUS_DIV,
        IUS_SQRT
    } ius_op_t;

    typedef struct packed {
        logic    start;
        ius_op_t op;
    } ius_req_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_CLR,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_V0, ST_V1, ST_V2, ST_V3,
        ST_R0, ST_R1, ST_R2, ST_R3, ST_R_WAIT,
        ST_W_START, ST_W_WAIT,
        ST_E_SUM,
        ST_A_START, ST_A_WAIT,
        ST_TRACK,
        ST_H0, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6,
        ST_L0, ST_L1, ST_L2, ST_L3, ST_L_WAIT,
        ST_P_MUL, ST_P_START, ST_P_WAIT,
        ST_RAT_START, ST_RAT_WAIT,
        ST_ECC_START, ST_ECC_WAIT,
        ST_E2_MUL, ST_S_START, ST_S_WAIT,
        ST_B_MUL, ST_B_CAP,
        ST_Q_START, ST_Q_WAIT,
        ST_T_MUL, ST_SQ_START, ST_SQ_WAIT,
        ST_PER_MUL, ST_PER_CAP,
        ST_OUT
    } state_t;

    // Signed value from sign and magnitude, saturated to the Q15.16 range.
    function automatic logic signed [31:0] sat_mag(input logic neg, input logic [64:0] mag);
        logic signed [31:0] r;
        if (neg) begin
            if (mag > 65'h80000000) r = Q_MIN;
            else r = -$signed(mag[31:0]);
        end else begin
            if (mag > 65'h7FFFFFFF) r = Q_MAX;
            else r = $signed(mag[31:0]);
        end
        return r;
    endfunction

    function automatic logic [30:0] umin31(input logic [64:0] v);
        logic [30:0] r;
        if (v > 65'h7FFFFFFF) r = 31'h7FFFFFFF;
        else r = v[30:0];
        return r;
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        logic [31:0] r;
        if (v[31]) r = 32'(-v);
        else r = 32'(v);
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/bpoe_mul.sv
// Shared multiplier of the orbit elements block: unsigned 34 x 32 product
// with a sign tag, one register stage. Depends on nothing but the clock.
`timescale 1ns / 1ps
`default_nettype none

module bpoe_mul (
    input  wire logic        aclk,
    input  wire logic [33:0] op_a,
    input  wire logic [31:0] op_b,
    input  wire logic        neg,
    output logic      [65:0] prod_reg,
    output logic             neg_reg
);

    always_ff @(posedge aclk) begin
        prod_reg <= 66'(op_a) * 66'(op_b);
        neg_reg  <= neg;
    end

endmodule

`default_nettype wire

>>> design/bpoe_ius.sv
// Iterative shared unit: restoring divider (one quotient bit a cycle) and
// digit-by-digit square root (one root bit a cycle). Uses bpoe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpoe_ius (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire bpoe_pkg::ius_req_t req,
    input  wire logic [63:0]       num,
    input  wire logic [32:0]       den,
    output logic                   done_reg,
    output logic [63:0]            res
);

    logic              busy_reg;
    bpoe_pkg::ius_op_t op_reg;
    logic [6:0]        cnt_reg;
    logic [63:0]       work_reg;
    logic [31:0]       root_reg;
    logic [33:0]       rem_reg;
    logic [32:0]       den_reg;
    logic [35:0]       x;
    logic [35:0]       y;
    logic [36:0]       diff;
    logic              ge;

    always_comb begin
        if (op_reg == bpoe_pkg::IUS_DIV) begin
            x = {1'b0, rem_reg, work_reg[63]};
            y = {3'b000, den_reg};
        end else begin
            x = {rem_reg, work_reg[63:62]};
            y = {2'b00, root_reg, 2'b01};
        end
        diff = {1'b0, x} - {1'b0, y};
        ge = !diff[36];
        res = (op_reg == bpoe_pkg::IUS_DIV) ? work_reg : {32'd0, root_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= bpoe_pkg::IUS_DIV;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                cnt_reg  <= (req.op == bpoe_pkg::IUS_DIV) ? bpoe_pkg::IUS_DIV_STEPS
                                                          : bpoe_pkg::IUS_SQRT_STEPS;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            work_reg <= num;
            root_reg <= '0;
            rem_reg  <= '0;
            den_reg  <= den;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[33:0] : x[33:0];
            if (op_reg == bpoe_pkg::IUS_DIV) begin
                work_reg <= {work_reg[62:0], ge};
            end else begin
                work_reg <= {work_reg[61:0], 2'b00};
                root_reg <= {root_reg[30:0], ge};
            end
        end
    end

endmodule

`default_nettype wire

>>> design/binary_pair_orbit_elements.sv
// Top level of the binary pair orbit elements block: sequencer, datapath
// registers, best-pair tracking and output register. Uses bpoe_pkg, bpoe_mul
// and bpoe_ius.
//
//   Channel  | Ports                      | Beat contents
//   ---------+----------------------------+---------------------------------
//   input    | s_tvalid s_tready s_tdata  | one body pair, new_scan in s_tuser
//   result   | m_tvalid m_tready m_tdata  | orbit elements, is_bound in m_tuser
//   config   | cfg_wr_en cfg_addr         | register write, no read-back
//
// A bound pair's time is set by up to five divisions of 64 steps and five
// square roots of 32 steps on the one shared iterative unit; unbound pairs
// skip the last division and square root, and skipped pairs never leave idle.
// Reset is synchronous; it clears the sequencer and best-pair tracking and
// loads default configuration. A stalled result waits in the output register
// while the next beat is taken in; the sequencer holds at its end until free.
`timescale 1ns / 1ps
`default_nettype none

module binary_pair_orbit_elements (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // first_index, second_index, mass_first, mass_second,
    // rel_pos_x, rel_pos_y, rel_pos_z, rel_vel_x, rel_vel_y, rel_vel_z
    input  wire logic [287:0] s_tdata,
    // new_scan
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // pair_first, pair_second, total_energy, potential, semi_major,
    // eccentricity, semi_minor, ang_momentum, period, best_first, best_second
    output logic      [279:0] m_tdata,
    // is_bound
    output logic              m_tuser,
    input  wire logic         cfg_wr_en,
    input  wire logic         cfg_addr,
    input  wire logic [14:0]  cfg_wr_data
);

    bpoe_pkg::state_t state_reg, state_next;

    logic        only_bound_reg;
    logic [14:0] body_count_reg;
    logic signed [31:0] best_pot_reg;
    logic [14:0] best_first_reg, best_second_reg;

    logic [13:0] i1_reg, i2_reg;
    logic [30:0] mu_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg, vx_reg, vy_reg, vz_reg;
    logic signed [31:0] t_kin_reg, w_reg, e_reg, a_reg, b_reg;
    logic signed [31:0] hx_reg, hy_reg, hz_reg;
    logic [31:0] r_reg;
    logic [30:0] l_reg, p_reg, rad_reg, q_reg, per_reg;
    logic [23:0] ecc_reg, s_reg, sq_reg;
    logic [33:0] t_reg;
    logic signed [65:0] acc_reg;

    logic         m_tvalid_reg;
    logic [279:0] m_tdata_reg;
    logic         m_tuser_reg;

    logic [33:0] mul_a;
    logic [31:0] mul_b;
    logic        mul_neg;
    logic [65:0] mul_p;
    logic        mul_p_neg;
    bpoe_pkg::acc_op_t acc_op;
    bpoe_pkg::ius_req_t ius_req;
    logic [63:0] ius_num;
    logic [32:0] ius_den;
    logic        ius_done;
    logic [63:0] ius_res;

    logic        in_acc;
    logic [14:0] limit;
    logic        skip;
    logic [31:0] mass_sum;
    logic signed [65:0] sp;
    logic signed [65:0] acc_sum;
    logic [65:0] acc_mag;
    logic signed [31:0] acc_q16;
    logic        bound;
    logic        drop;
    logic        out_free;
    logic [31:0] abs_a, abs_e;
    logic signed [32:0] te_sum;
    logic signed [31:0] ratio;
    logic signed [33:0] rad_full;
    logic [31:0] e2;
    logic [31:0] dd;

    bpoe_mul u_mul (
        .aclk     (aclk),
        .op_a     (mul_a),
        .op_b     (mul_b),
        .neg      (mul_neg),
        .prod_reg (mul_p),
        .neg_reg  (mul_p_neg)
    );

    bpoe_ius u_ius (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (ius_req),
        .num      (ius_num),
        .den      (ius_den),
        .done_reg (ius_done),
        .res      (ius_res)
    );

    assign in_acc   = s_tvalid && s_tready;
    assign limit    = (body_count_reg > bpoe_pkg::MAX_BODIES_LIM) ? bpoe_pkg::MAX_BODIES_LIM
                                                                   : body_count_reg;
    assign skip     = (s_tdata[13:0] >= s_tdata[27:14]) || ({1'b0, s_tdata[27:14]} >= limit)
                      || ({1'b0, s_tdata[13:0]} >= limit);
    assign mass_sum = {1'b0, s_tdata[58:28]} + {1'b0, s_tdata[89:59]};
    assign sp       = mul_p_neg ? -$signed({1'b0, mul_p[64:0]}) : $signed({1'b0, mul_p[64:0]});
    assign acc_sum  = acc_reg + sp;
    assign acc_mag  = acc_sum[65] ? 66'(-acc_sum) : 66'(acc_sum);
    assign acc_q16  = bpoe_pkg::sat_mag(acc_sum[65], acc_mag[65:16] > 50'h1FFFFFFFFFFFF ?
                                        65'h1FFFFFFFFFFFFFFFF : 65'(acc_mag[65:16]));
    assign bound    = (a_reg > 32'sd0);
    assign drop     = !bound && only_bound_reg;
    assign out_free = !m_tvalid_reg || m_tready;
    assign abs_a    = bpoe_pkg::abs32(a_reg);
    assign abs_e    = bpoe_pkg::abs32(e_reg);
    assign te_sum   = 33'(t_kin_reg) + 33'(w_reg);
    assign ratio    = bpoe_pkg::sat_mag(a_reg[31], 65'(ius_res));
    assign rad_full = 34'sd65536 - 34'(ratio);
    assign e2       = mul_p[47:16];
    assign dd       = (e2 > 32'(bpoe_pkg::ONE_Q)) ? e2 - 32'(bpoe_pkg::ONE_Q)
                                                  : 32'(bpoe_pkg::ONE_Q) - e2;

    assign s_tready = (state_reg == bpoe_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bpoe_pkg::ST_IDLE:      if (in_acc && !skip) state_next = bpoe_pkg::ST_V0;
            bpoe_pkg::ST_V0:        state_next = bpoe_pkg::ST_V1;
            bpoe_pkg::ST_V1:        state_next = bpoe_pkg::ST_V2;
            bpoe_pkg::ST_V2:        state_next = bpoe_pkg::ST_V3;
            bpoe_pkg::ST_V3:        state_next = bpoe_pkg::ST_R0;
            bpoe_pkg::ST_R0:        state_next = bpoe_pkg::ST_R1;
            bpoe_pkg::ST_R1:        state_next = bpoe_pkg::ST_R2;
            bpoe_pkg::ST_R2:        state_next = bpoe_pkg::ST_R3;
            bpoe_pkg::ST_R3:        state_next = bpoe_pkg::ST_R_WAIT;
            bpoe_pkg::ST_R_WAIT:    if (ius_done) state_next = bpoe_pkg::ST_W_START;
            bpoe_pkg::ST_W_START:   state_next = (r_reg == 32'd0) ? bpoe_pkg::ST_E_SUM
                                                                  : bpoe_pkg::ST_W_WAIT;
            bpoe_pkg::ST_W_WAIT:    if (ius_done) state_next = bpoe_pkg::ST_E_SUM;
            bpoe_pkg::ST_E_SUM:     state_next = bpoe_pkg::ST_A_START;
            bpoe_pkg::ST_A_START:   state_next = (e_reg == 32'sd0) ? bpoe_pkg::ST_TRACK
                                                                   : bpoe_pkg::ST_A_WAIT;
            bpoe_pkg::ST_A_WAIT:    if (ius_done) state_next = bpoe_pkg::ST_TRACK;
            bpoe_pkg::ST_TRACK:     state_next = bpoe_pkg::ST_H0;
            bpoe_pkg::ST_H0:        state_next = bpoe_pkg::ST_H1;
            bpoe_pkg::ST_H1:        state_next = bpoe_pkg::ST_H2;
            bpoe_pkg::ST_H2:        state_next = bpoe_pkg::ST_H3;
            bpoe_pkg::ST_H3:        state_next = bpoe_pkg::ST_H4;
            bpoe_pkg::ST_H4:        state_next = bpoe_pkg::ST_H5;
            bpoe_pkg::ST_H5:        state_next = bpoe_pkg::ST_H6;
            bpoe_pkg::ST_H6:        state_next = bpoe_pkg::ST_L0;
            bpoe_pkg::ST_L0:        state_next = bpoe_pkg::ST_L1;
            bpoe_pkg::ST_L1:        state_next = bpoe_pkg::ST_L2;
            bpoe_pkg::ST_L2:        state_next = bpoe_pkg::ST_L3;
            bpoe_pkg::ST_L3:        state_next = bpoe_pkg::ST_L_WAIT;
            bpoe_pkg::ST_L_WAIT:    if (ius_done) state_next = bpoe_pkg::ST_P_MUL;
            bpoe_pkg::ST_P_MUL:     state_next = (mu_reg == 31'd0) ? bpoe_pkg::ST_RAT_START
                                                                   : bpoe_pkg::ST_P_START;
            bpoe_pkg::ST_P_START:   state_next = bpoe_pkg::ST_P_WAIT;
            bpoe_pkg::ST_P_WAIT:    if (ius_done) state_next = bpoe_pkg::ST_RAT_START;
            bpoe_pkg::ST_RAT_START: state_next = (a_reg == 32'sd0) ? bpoe_pkg::ST_ECC_START
                                                                   : bpoe_pkg::ST_RAT_WAIT;
            bpoe_pkg::ST_RAT_WAIT:  if (ius_done) state_next = bpoe_pkg::ST_ECC_START;
            bpoe_pkg::ST_ECC_START: state_next = bpoe_pkg::ST_ECC_WAIT;
            bpoe_pkg::ST_ECC_WAIT:  if (ius_done) state_next = bpoe_pkg::ST_E2_MUL;
            bpoe_pkg::ST_E2_MUL:    state_next = bpoe_pkg::ST_S_START;
            bpoe_pkg::ST_S_START:   state_next = bpoe_pkg::ST_S_WAIT;
            bpoe_pkg::ST_S_WAIT:    if (ius_done) state_next = bpoe_pkg::ST_B_MUL;
            bpoe_pkg::ST_B_MUL:     state_next = bpoe_pkg::ST_B_CAP;
            bpoe_pkg::ST_B_CAP:     state_next = bound ? bpoe_pkg::ST_Q_START : bpoe_pkg::ST_OUT;
            bpoe_pkg::ST_Q_START:   state_next = (mu_reg == 31'd0) ? bpoe_pkg::ST_T_MUL
                                                                   : bpoe_pkg::ST_Q_WAIT;
            bpoe_pkg::ST_Q_WAIT:    if (ius_done) state_next = bpoe_pkg::ST_T_MUL;
            bpoe_pkg::ST_T_MUL:     state_next = bpoe_pkg::ST_SQ_START;
            bpoe_pkg::ST_SQ_START:  state_next = bpoe_pkg::ST_SQ_WAIT;
            bpoe_pkg::ST_SQ_WAIT:   if (ius_done) state_next = bpoe_pkg::ST_PER_MUL;
            bpoe_pkg::ST_PER_MUL:   state_next = bpoe_pkg::ST_PER_CAP;
            bpoe_pkg::ST_PER_CAP:   state_next = bpoe_pkg::ST_OUT;
            bpoe_pkg::ST_OUT:       if (drop || out_free) state_next = bpoe_pkg::ST_IDLE;
            default:                state_next = bpoe_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        mul_a         = '0;
        mul_b         = '0;
        mul_neg       = 1'b0;
        acc_op        = bpoe_pkg::ACC_HOLD;
        ius_req.start = 1'b0;
        ius_req.op    = bpoe_pkg::IUS_DIV;
        ius_num       = '0;
        ius_den       = '0;
        case (state_reg)
            bpoe_pkg::ST_V0: begin
                mul_a = 34'(bpoe_pkg::abs32(vx_reg));
                mul_b = bpoe_pkg::abs32(vx_reg);
            end
            bpoe_pkg::ST_V1: begin
                mul_a  = 34'(bpoe_pkg::abs32(vy_reg));
                mul_b  = bpoe_pkg::abs32(vy_reg);
                acc_op = bpoe_pkg::ACC_LOAD;
            end
            bpoe_pkg::ST_V2: begin
                mul_a  = 34'(bpoe_pkg::abs32(vz_reg));
                mul_b  = bpoe_pkg::abs32(vz_reg);
                acc_op = bpoe_pkg::ACC_ADD;
            end
            bpoe_pkg::ST_R0: begin
                mul_a = 34'(bpoe_pkg::abs32(px_reg));
                mul_b = bpoe_pkg::abs32(px_reg);
            end
            bpoe_pkg::ST_R1: begin
                mul_a  = 34'(bpoe_pkg::abs32(py_reg));
                mul_b  = bpoe_pkg::abs32(py_reg);
                acc_op = bpoe_pkg::ACC_LOAD;
            end
            bpoe_pkg::ST_R2: begin
                mul_a  = 34'(bpoe_pkg::abs32(pz_reg));
                mul_b  = bpoe_pkg::abs32(pz_reg);
                acc_op = bpoe_pkg::ACC_ADD;
            end
            bpoe_pkg::ST_R3: begin
                ius_req.start = 1'b1;
                ius_req.op    = bpoe_pkg::IUS_SQRT;
                ius_num       = acc_sum[63:0];
            end
            bpoe_pkg::ST_W_START: begin
                ius_req.start = (r_reg != 32'd0);
                ius_num       = {17'd0, mu_reg, 16'd0};
                ius_den       = {1'b0, r_reg};
            end
            bpoe_pkg::ST_A_START: begin
                ius_req.start = (e_reg != 32'sd0);
                ius_num       = {17'd0, mu_reg, 16'd0};
                ius_den       = {abs_e, 1'b0};
            end
            bpoe_pkg::ST_H0: begin
                mul_a   = 34'(bpoe_pkg::abs32(py_reg));
                mul_b   = bpoe_pkg::abs32(vz_reg);
                mul_neg = py_reg[31] ^ vz_reg[31];
            end
            bpoe_pkg::ST_H1: begin
                mul_a   = 34'(bpoe_pkg::abs32(pz_reg));
                mul_b   = bpoe_pkg::abs32(vy_reg);
                mul_neg = !(pz_reg[31] ^ vy_reg[31]);
                acc_op  = bpoe_pkg::ACC_LOAD;
            end
            bpoe_pkg::ST_H2: begin
                mul_a   = 34'(bpoe_pkg::abs32(pz_reg));
                mul_b   = bpoe_pkg::abs32(vx_reg);
                mul_neg = pz_reg[31] ^ vx_reg[31];
            end
            bpoe_pkg::ST_H3: begin
                mul_a   = 34'(bpoe_pkg::abs32(px_reg));
                mul_b   = bpoe_pkg::abs32(vz_reg);
                mul_neg = !(px_reg[31] ^ vz_reg[31]);
                acc_op  = bpoe_pkg::ACC_LOAD;
            end
            bpoe_pkg::ST_H4: begin
                mul_a   = 34'(bpoe_pkg::abs32(px_reg));
                mul_b   = bpoe_pkg::abs32(vy_reg);
                mul_neg = px_reg[31] ^ vy_reg[31];
            end
            bpoe_pkg::ST_H5: begin
                mul_a   = 34'(bpoe_pkg::abs32(py_reg));
                mul_b   = bpoe_pkg::abs32(vx_reg);
                mul_neg = !(py_reg[31] ^ vx_reg[31]);
                acc_op  = bpoe_pkg::ACC_LOAD;
            end
            bpoe_pkg::ST_L0: begin
                mul_a = 34'(bpoe_pkg::abs32(hx_reg));
                mul_b = bpoe_pkg::abs32(hx_reg);
            end
            bpoe_pkg::ST_L1: begin
                mul_a  = 34'(bpoe_pkg::abs32(hy_reg));
                mul_b  = bpoe_pkg::abs32(hy_reg);
                acc_op = bpoe_pkg::ACC_LOAD;
            end
            bpoe_pkg::ST_L2: begin
                mul_a  = 34'(bpoe_pkg::abs32(hz_reg));
                mul_b  = bpoe_pkg::abs32(hz_reg);
                acc_op = bpoe_pkg::ACC_ADD;
            end
            bpoe_pkg::ST_L3: begin
                ius_req.start = 1'b1;
                ius_req.op    = bpoe_pkg::IUS_SQRT;
                ius_num       = acc_sum[63:0];
            end
            bpoe_pkg::ST_P_MUL: begin
                mul_a = 34'(l_reg);
                mul_b = 32'(l_reg);
            end
            bpoe_pkg::ST_P_START: begin
                ius_req.start = 1'b1;
                ius_num       = mul_p[63:0];
                ius_den       = 33'(mu_reg);
            end
            bpoe_pkg::ST_RAT_START: begin
                ius_req.start = (a_reg != 32'sd0);
                ius_num       = {17'd0, p_reg, 16'd0};
                ius_den       = 33'(abs_a);
            end
            bpoe_pkg::ST_ECC_START: begin
                ius_req.start = 1'b1;
                ius_req.op    = bpoe_pkg::IUS_SQRT;
                ius_num       = {17'd0, rad_reg, 16'd0};
            end
            bpoe_pkg::ST_E2_MUL: begin
                mul_a = 34'(ecc_reg);
                mul_b = 32'(ecc_reg);
            end
            bpoe_pkg::ST_S_START: begin
                ius_req.start = 1'b1;
                ius_req.op    = bpoe_pkg::IUS_SQRT;
                ius_num       = {16'd0, dd, 16'd0};
            end
            bpoe_pkg::ST_B_MUL: begin
                mul_a = 34'(abs_a);
                mul_b = 32'(s_reg);
            end
            bpoe_pkg::ST_Q_START: begin
                ius_req.start = (mu_reg != 31'd0);
                ius_num       = {16'd0, a_reg, 16'd0};
                ius_den       = 33'(mu_reg);
            end
            bpoe_pkg::ST_T_MUL: begin
                mul_a = 34'(a_reg);
                mul_b = 32'(bpoe_pkg::TWO_PI_Q);
            end
            bpoe_pkg::ST_SQ_START: begin
                ius_req.start = 1'b1;
                ius_req.op    = bpoe_pkg::IUS_SQRT;
                ius_num       = {17'd0, q_reg, 16'd0};
            end
            bpoe_pkg::ST_PER_MUL: begin
                mul_a = t_reg;
                mul_b = 32'(sq_reg);
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= bpoe_pkg::ST_IDLE;
            only_bound_reg  <= 1'b1;
            body_count_reg  <= bpoe_pkg::MAX_BODIES_LIM;
            best_pot_reg    <= '0;
            best_first_reg  <= '1;
            best_second_reg <= '1;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    bpoe_pkg::CFG_ONLY_BOUND: only_bound_reg <= cfg_wr_data[0];
                    bpoe_pkg::CFG_BODY_COUNT: body_count_reg <= cfg_wr_data;
                    default:                  only_bound_reg <= only_bound_reg;
                endcase
            end
            if (in_acc && s_tuser) begin
                best_pot_reg    <= '0;
                best_first_reg  <= '1;
                best_second_reg <= '1;
            end else if (state_reg == bpoe_pkg::ST_TRACK && bound && w_reg < best_pot_reg) begin
                best_pot_reg    <= w_reg;
                best_first_reg  <= {1'b0, i1_reg};
                best_second_reg <= {1'b0, i2_reg};
            end
            if (state_reg == bpoe_pkg::ST_OUT && !drop && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (acc_op)
            bpoe_pkg::ACC_CLR:  acc_reg <= '0;
            bpoe_pkg::ACC_LOAD: acc_reg <= sp;
            bpoe_pkg::ACC_ADD:  acc_reg <= acc_sum;
            default:            acc_reg <= acc_reg;
        endcase
        if (in_acc) begin
            i1_reg <= s_tdata[13:0];
            i2_reg <= s_tdata[27:14];
            mu_reg <= mass_sum[31] ? 31'h7FFFFFFF : mass_sum[30:0];
            px_reg <= s_tdata[121:90];
            py_reg <= s_tdata[153:122];
            pz_reg <= s_tdata[185:154];
            vx_reg <= s_tdata[217:186];
            vy_reg <= s_tdata[249:218];
            vz_reg <= s_tdata[281:250];
        end
        case (state_reg)
            bpoe_pkg::ST_V3:
                t_kin_reg <= $signed({1'b0, bpoe_pkg::umin31(65'(acc_sum[63:17]))});
            bpoe_pkg::ST_R_WAIT:
                if (ius_done) r_reg <= ius_res[31:0];
            bpoe_pkg::ST_W_START:
                if (r_reg == 32'd0) w_reg <= bpoe_pkg::Q_MIN;
            bpoe_pkg::ST_W_WAIT:
                if (ius_done) w_reg <= bpoe_pkg::sat_mag(1'b1, 65'(ius_res));
            bpoe_pkg::ST_E_SUM:
                e_reg <= bpoe_pkg::sat_mag(te_sum[32], te_sum[32] ? 65'(-te_sum) : 65'(te_sum));
            bpoe_pkg::ST_A_START:
                if (e_reg == 32'sd0) a_reg <= bpoe_pkg::Q_MIN;
            bpoe_pkg::ST_A_WAIT:
                if (ius_done) a_reg <= bpoe_pkg::sat_mag(!e_reg[31], 65'(ius_res));
            bpoe_pkg::ST_H2:        hx_reg <= acc_q16;
            bpoe_pkg::ST_H4:        hy_reg <= acc_q16;
            bpoe_pkg::ST_H6:        hz_reg <= acc_q16;
            bpoe_pkg::ST_L_WAIT:
                if (ius_done) l_reg <= bpoe_pkg::umin31(65'(ius_res));
            bpoe_pkg::ST_P_MUL:
                if (mu_reg == 31'd0) p_reg <= 31'h7FFFFFFF;
            bpoe_pkg::ST_P_WAIT:
                if (ius_done) p_reg <= bpoe_pkg::umin31(65'(ius_res));
            bpoe_pkg::ST_RAT_START:
                if (a_reg == 32'sd0) rad_reg <= '0;
            bpoe_pkg::ST_RAT_WAIT:
                if (ius_done) begin
                    if (rad_full[33]) rad_reg <= '0;
                    else if (rad_full > 34'sh7FFFFFFF) rad_reg <= 31'h7FFFFFFF;
                    else rad_reg <= rad_full[30:0];
                end
            bpoe_pkg::ST_ECC_WAIT:
                if (ius_done) ecc_reg <= ius_res[23:0];
            bpoe_pkg::ST_S_WAIT:
                if (ius_done) s_reg <= ius_res[23:0];
            bpoe_pkg::ST_B_CAP: begin
                b_reg <= bpoe_pkg::sat_mag(a_reg[31], 65'(mul_p[65:16]));
                if (!bound) per_reg <= '0;
            end
            bpoe_pkg::ST_Q_START:
                if (mu_reg == 31'd0) q_reg <= 31'h7FFFFFFF;
            bpoe_pkg::ST_Q_WAIT:
                if (ius_done) q_reg <= bpoe_pkg::umin31(65'(ius_res));
            bpoe_pkg::ST_SQ_START:  t_reg <= mul_p[49:16];
            bpoe_pkg::ST_SQ_WAIT:
                if (ius_done) sq_reg <= ius_res[23:0];
            bpoe_pkg::ST_PER_CAP:   per_reg <= bpoe_pkg::umin31(65'(mul_p[65:16]));
            default:                t_reg <= t_reg;
        endcase
        if (state_reg == bpoe_pkg::ST_OUT && !drop && out_free) begin
            m_tuser_reg <= bound;
            m_tdata_reg <= {1'b0, best_second_reg, best_first_reg, per_reg, l_reg, b_reg,
                            ecc_reg[23:0] == ecc_reg ? {7'd0, ecc_reg} : 31'd0,
                            a_reg, w_reg, e_reg, i2_reg, i1_reg};
        end
    end

    ap_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        ius_done |-> (state_reg == bpoe_pkg::ST_R_WAIT || state_reg == bpoe_pkg::ST_W_WAIT ||
                      state_reg == bpoe_pkg::ST_A_WAIT || state_reg == bpoe_pkg::ST_L_WAIT ||
                      state_reg == bpoe_pkg::ST_P_WAIT || state_reg == bpoe_pkg::ST_RAT_WAIT ||
                      state_reg == bpoe_pkg::ST_ECC_WAIT || state_reg == bpoe_pkg::ST_S_WAIT ||
                      state_reg == bpoe_pkg::ST_Q_WAIT || state_reg == bpoe_pkg::ST_SQ_WAIT))
        else $error("iterative unit finished outside a wait state");

    ap_unbound_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tuser_reg) |-> !only_bound_reg)
        else $error("unbound result shown while only bound pairs are enabled");

    ap_best_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (best_first_reg != 15'h7FFF) |-> (best_first_reg < best_second_reg))
        else $error("tracked best pair is out of order");

endmodule

`default_nettype wire
